[rtl/core/vlss_pkg.sv]
package vlss_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRACTION_BITS = 8;
    localparam int DIFF_W        = COORD_BITS + 1;

    // Node and camera are brought to chunk units by a divide by 2^CHUNK_LOG2.
    localparam int CHUNK_LOG2 = 4;
    // Estimate threshold is 2 * shell * 2^k chunk units.
    localparam int EST_BASE   = 1 + CHUNK_LOG2 + FRACTION_BITS;
    // Shell grid is 2^(L+2) * 2^scale chunk units.
    localparam int GRID_BASE  = 2 + CHUNK_LOG2 + FRACTION_BITS;
    // Beyond this k the shifted distance is always zero.
    localparam int K_MAX      = COORD_BITS - EST_BASE;

    localparam int LVL_W     = 5;
    localparam int EST_W     = LVL_W;
    localparam int LEVEL_SAT = 31;
    localparam int SHELL_W   = 8;
    localparam int EXPO_W    = 5;
    localparam int EXT_W     = 16;
    localparam int G_W       = 7;
    localparam int SH_W      = $clog2(COORD_BITS);

    localparam int IN_DATA_W  = 3 * COORD_BITS + EXT_W;
    localparam int OUT_DATA_W = 8;

    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_CAM_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAM_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAM_Z   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHELL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_EXPO    = 3'd4;
    localparam logic [IDX_W-1:0] REG_LARGEST = 3'd5;

    localparam logic [SHELL_W-1:0] SHELL_RESET   = 8'd2;
    localparam logic [EXPO_W-1:0]  EXPO_RESET    = 5'd0;
    localparam logic [EXT_W-1:0]   LARGEST_RESET = 16'd64;

    typedef logic [2:0][COORD_BITS-1:0] t_coord3;

    typedef struct packed {
        t_coord3              cam;
        logic [SHELL_W-1:0]   shell;
        logic [EXPO_W-1:0]    expo;
        logic [EXT_W-1:0]     largest;
    } t_cfg;

    typedef struct packed {
        logic                   force_zero;
        logic                   force_max;
        logic [EST_W-1:0]       est;
        logic [2:0][DIFF_W-1:0] absd;
    } t_est;

endpackage

[rtl/core/voxel_lod_shell_select.sv]
// Level-of-detail selection for a stream of octree nodes.
// Input channel s_*: one beat per node carrying center x, y, z (signed fixed
// point, 8 fraction bits) and the node edge size. Output channel m_*: one
// beat per node carrying the 5-bit detail level, in input order.
// The APB port holds the frozen camera position, shell width, scale exponent
// and the largest chunk size; write it only while no node is in flight.
// The edge that accepts a node loads the input register; the node then moves
// on to the estimate register and then to the result register, whose valid
// flag drives m_tvalid.
// Throughput: one node per cycle while m_tready is high; every stage is short
// compare, shift and add logic, so the three registers form a plain pipeline.
// A stalled receiver holds the result register; the stages behind it keep
// filling until all three are full, and only then is s_tready dropped.
// Reset clears all stage valid flags and loads the register defaults:
// camera at the origin, shell width 2, scale exponent 0, largest chunk 64.
module voxel_lod_shell_select
    import vlss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // center_x [31:0], center_y [63:32], center_z [95:64], node_extent [111:96]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // detail_level [4:0], zero fill [7:5]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    t_cfg             w_cfg;
    t_est             w_est;
    logic [LVL_W-1:0] w_level;

    logic             r_v1;
    t_coord3          r_node1;
    logic [EXT_W-1:0] r_ext1;
    logic             r_v2;
    t_coord3          r_node2;
    t_est             r_est;
    logic             r_v3;
    logic [LVL_W-1:0] r_level;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    vlss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    vlss_estimate u_estimate (
        .i_node   (r_node1),
        .i_extent (r_ext1),
        .i_cfg    (w_cfg),
        .o_est    (w_est)
    );

    vlss_shell_fix u_shell_fix (
        .i_node  (r_node2),
        .i_est   (r_est),
        .i_cfg   (w_cfg),
        .o_level (w_level)
    );

    // A stage may load when it is empty or its content moves on this cycle.
    assign w_rdy3   = !r_v3 || m_tready;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign s_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && s_tvalid) begin
            for (int a = 0; a < 3; a++) begin
                r_node1[a] <= s_tdata[a*COORD_BITS +: COORD_BITS];
            end
            r_ext1 <= s_tdata[3*COORD_BITS +: EXT_W];
        end
        if (w_rdy2 && r_v1) begin
            r_node2 <= r_node1;
            r_est   <= w_est;
        end
        if (w_rdy3 && r_v2) begin
            r_level <= w_level;
        end
    end

    assign m_tvalid = r_v3;
    assign m_tdata  = {{(OUT_DATA_W-LVL_W){1'b0}}, r_level};

`ifndef SYNTHESIS
    a_est_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy3) |=> (r_v2 && $stable(r_est) && $stable(r_node2)))
        else $error("estimate stage changed while blocked");

    a_force_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && r_est.force_zero) |=> (r_v3 && (r_level == '0)))
        else $error("oversized node did not get level zero");

    a_level_near_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && !r_est.force_zero && !r_est.force_max)
        |=> (({1'b0, r_level} + 6'd1 >= {1'b0, $past(r_est.est)})
          && ({1'b0, r_level} <= {1'b0, $past(r_est.est)} + 6'd1)))
        else $error("corrected level strays more than one from the estimate");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((r_level <= LVL_W'(K_MAX + 1)) || (r_level == LVL_W'(LEVEL_SAT))))
        else $error("level outside the reachable range");
`endif

endmodule

[rtl/core/vlss_cfg_regs.sv]
module vlss_cfg_regs
    import vlss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [COORD_BITS-1:0] r_cam_x;
    logic [COORD_BITS-1:0] r_cam_y;
    logic [COORD_BITS-1:0] r_cam_z;
    logic [SHELL_W-1:0]    r_shell;
    logic [EXPO_W-1:0]     r_expo;
    logic [EXT_W-1:0]      r_largest;
    logic [IDX_W-1:0]      w_idx;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x   <= '0;
            r_cam_y   <= '0;
            r_cam_z   <= '0;
            r_shell   <= SHELL_RESET;
            r_expo    <= EXPO_RESET;
            r_largest <= LARGEST_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_CAM_X:   r_cam_x   <= pwdata[COORD_BITS-1:0];
                REG_CAM_Y:   r_cam_y   <= pwdata[COORD_BITS-1:0];
                REG_CAM_Z:   r_cam_z   <= pwdata[COORD_BITS-1:0];
                REG_SHELL:   r_shell   <= pwdata[SHELL_W-1:0];
                REG_EXPO:    r_expo    <= pwdata[EXPO_W-1:0];
                REG_LARGEST: r_largest <= pwdata[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CAM_X:   prdata = r_cam_x;
            REG_CAM_Y:   prdata = r_cam_y;
            REG_CAM_Z:   prdata = r_cam_z;
            REG_SHELL:   prdata = {{(APB_DATA_W-SHELL_W){1'b0}}, r_shell};
            REG_EXPO:    prdata = {{(APB_DATA_W-EXPO_W){1'b0}}, r_expo};
            REG_LARGEST: prdata = {{(APB_DATA_W-EXT_W){1'b0}}, r_largest};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.cam     = {r_cam_z, r_cam_y, r_cam_x};
    assign o_cfg.shell   = r_shell;
    assign o_cfg.expo    = r_expo;
    assign o_cfg.largest = r_largest;

endmodule

[rtl/core/vlss_estimate.sv]
module vlss_estimate
    import vlss_pkg::*;
(
    input  t_coord3          i_node,
    input  logic [EXT_W-1:0] i_extent,
    input  t_cfg             i_cfg,
    output t_est             o_est
);

    logic signed [DIFF_W-1:0] w_diff [3];
    logic [2:0][DIFF_W-1:0]   w_absd;
    logic [DIFF_W-1:0]        w_dmax;
    logic [DIFF_W-1:0]        w_shell_ext;
    logic [EST_W-1:0]         w_est;

    assign w_shell_ext = {{(DIFF_W-SHELL_W){1'b0}}, i_cfg.shell};

    always_comb begin
        w_dmax = '0;
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = $signed({i_node[a][COORD_BITS-1], i_node[a]})
                      - $signed({i_cfg.cam[a][COORD_BITS-1], i_cfg.cam[a]});
            w_absd[a] = w_diff[a][DIFF_W-1] ? DIFF_W'(-w_diff[a]) : DIFF_W'(w_diff[a]);
            if (w_absd[a] > w_dmax) begin
                w_dmax = w_absd[a];
            end
        end
    end

    // The thresholds grow with k, so the highest passing k is the estimate.
    always_comb begin
        w_est = '0;
        for (int k = 1; k <= K_MAX; k++) begin
            if ((w_dmax >> (k + EST_BASE)) >= w_shell_ext) begin
                w_est = EST_W'(k);
            end
        end
    end

    assign o_est.force_zero = (i_extent > i_cfg.largest);
    assign o_est.force_max  = (i_cfg.shell == '0);
    assign o_est.est        = w_est;
    assign o_est.absd       = w_absd;

endmodule

[rtl/core/vlss_shell_fix.sv]
module vlss_shell_fix
    import vlss_pkg::*;
(
    input  t_coord3          i_node,
    input  t_est             i_est,
    input  t_cfg             i_cfg,
    output logic [LVL_W-1:0] o_level
);

    // One axis of the shell test. For a grid of 2^g units the snapped
    // distance divided by the grid equals the difference of the floored
    // grid indices, less one when the node lies below the camera cell and
    // off a grid line.
    function automatic logic axis_in(
        input logic [COORD_BITS-1:0] node,
        input logic [COORD_BITS-1:0] cam,
        input logic [DIFF_W-1:0]     absd,
        input logic signed [G_W-1:0] g,
        input logic [SHELL_W-1:0]    shell
    );
        logic [SH_W-1:0]              gs;
        logic signed [COORD_BITS-1:0] ns;
        logic signed [COORD_BITS-1:0] cs;
        logic signed [DIFF_W-1:0]     dq;
        logic [COORD_BITS-1:0]        lowm;
        logic                         rnz;
        logic [DIFF_W-1:0]            q;
        logic [G_W-1:0]               ng;
        logic [3:0]                   s;
        logic [23:0]                  dsh;
        logic                         res;
        if (g < 0) begin
            // Grid finer than one unit: the camera stays unsnapped.
            ng  = G_W'(-g);
            s   = (ng > G_W'(15)) ? 4'd15 : ng[3:0];
            dsh = {16'b0, absd[7:0]} << s;
            res = (absd < {{(DIFF_W-SHELL_W){1'b0}}, shell})
               && (dsh < {16'b0, shell});
        end else begin
            gs   = (g > (COORD_BITS - 1)) ? SH_W'(COORD_BITS - 1) : g[SH_W-1:0];
            ns   = $signed(node) >>> gs;
            cs   = $signed(cam) >>> gs;
            dq   = $signed({ns[COORD_BITS-1], ns}) - $signed({cs[COORD_BITS-1], cs});
            lowm = (g > (COORD_BITS - 1)) ? {COORD_BITS{1'b1}}
                                          : ~({COORD_BITS{1'b1}} << gs);
            rnz  = |(node & lowm);
            if (dq[DIFF_W-1]) begin
                q = rnz ? DIFF_W'(~dq) : DIFF_W'(-dq);
            end else begin
                q = DIFF_W'(dq);
            end
            res = (q < {{(DIFF_W-SHELL_W){1'b0}}, shell});
        end
        return res;
    endfunction

    logic signed [G_W-1:0] w_est_s;
    logic signed [G_W-1:0] w_expo_s;
    logic signed [G_W-1:0] w_g_est;
    logic signed [G_W-1:0] w_g_prev;
    logic                  w_in_est;
    logic                  w_in_prev;
    logic [LVL_W:0]        w_lvl;

    assign w_est_s  = $signed(G_W'(i_est.est));
    assign w_expo_s = G_W'($signed(i_cfg.expo));
    assign w_g_est  = w_est_s + w_expo_s + G_W'(GRID_BASE);
    assign w_g_prev = w_g_est - G_W'(1);

    always_comb begin
        w_in_est  = 1'b1;
        w_in_prev = 1'b1;
        for (int a = 0; a < 3; a++) begin
            w_in_est  = w_in_est
                      & axis_in(i_node[a], i_cfg.cam[a], i_est.absd[a], w_g_est, i_cfg.shell);
            w_in_prev = w_in_prev
                      & axis_in(i_node[a], i_cfg.cam[a], i_est.absd[a], w_g_prev, i_cfg.shell);
        end
    end

    always_comb begin
        if (i_est.force_zero) begin
            w_lvl = '0;
        end else if (i_est.force_max) begin
            w_lvl = (LVL_W+1)'(LEVEL_SAT);
        end else if (!w_in_est) begin
            w_lvl = {1'b0, i_est.est} + (LVL_W+1)'(1);
        end else if ((i_est.est == '0) || !w_in_prev) begin
            w_lvl = {1'b0, i_est.est};
        end else begin
            w_lvl = {1'b0, i_est.est} - (LVL_W+1)'(1);
        end
    end

    assign o_level = (w_lvl > (LVL_W+1)'(LEVEL_SAT)) ? LVL_W'(LEVEL_SAT) : w_lvl[LVL_W-1:0];

endmodule

[dv/tb_voxel_lod_shell_select.sv]
module tb_voxel_lod_shell_select;
    import vlss_pkg::*;

    typedef longint unsigned t_u64;
    typedef enum logic {ROW_NODE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [IDX_W-1:0]      reg_idx;
        logic [APB_DATA_W-1:0] value;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
        logic [EXT_W-1:0]      ext;
        bit                    known;
        logic [LVL_W-1:0]      level;
    } t_stim_row;

    localparam int QUIET_LIMIT       = 4000;
    localparam int RANDOM_SEGMENTS   = 8;
    localparam int NODES_PER_SEGMENT = 100;
    localparam int HOLD_CYCLES       = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // center_x [31:0], center_y [63:32], center_z [95:64], node_extent [111:96]
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // detail_level [4:0], zero fill [7:5]
    logic [OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the configuration registers.
    logic [COORD_BITS-1:0] cam_x;
    logic [COORD_BITS-1:0] cam_y;
    logic [COORD_BITS-1:0] cam_z;
    logic [SHELL_W-1:0]    shell_cells;
    logic [EXPO_W-1:0]     scale_expo;
    logic [EXT_W-1:0]      largest_chunk;

    logic [LVL_W-1:0] pending_levels[$];
    logic [LVL_W-1:0] want_level;
    t_stim_row        directed_rows[$];
    int               errors;
    int               quiet;
    int               rx_hold;
    int               src_idle_pct;
    int               dst_idle_pct;

    voxel_lod_shell_select dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_u64 mag64(input longint v);
        return (v < 0) ? t_u64'(-v) : t_u64'(v);
    endfunction

    // One axis of the shell test; g is log2 of the grid in units of 2^-12 chunk.
    function automatic bit axis_fits(input longint node, input longint cam, input int g,
                                     input t_u64 shell);
        t_u64   low;
        t_u64   d;
        longint snapped;
        if (g >= 56) begin
            if (cam >= 0)
                return shell > 0;
            return (shell > 1) || (shell == 1 && node < 0);
        end
        if (g >= 0) begin
            low = (t_u64'(1) << g) - 1;
            snapped = cam - longint'($unsigned(cam) & low);
            d = mag64(node - snapped);
            return (d >> g) < shell;
        end
        // A grid finer than one unit leaves the camera where it is.
        d = mag64(node - cam);
        if (d >= shell)
            return 1'b0;
        return (d << (-g)) < shell;
    endfunction

    function automatic bit shell_holds(input int g, input longint nx, input longint ny,
                                       input longint nz, input t_u64 shell);
        return axis_fits(nx, longint'($signed(cam_x)), g, shell) &&
               axis_fits(ny, longint'($signed(cam_y)), g, shell) &&
               axis_fits(nz, longint'($signed(cam_z)), g, shell);
    endfunction

    function automatic logic [LVL_W-1:0] predict_level(input logic [COORD_BITS-1:0] cx,
                                                       input logic [COORD_BITS-1:0] cy,
                                                       input logic [COORD_BITS-1:0] cz,
                                                       input logic [EXT_W-1:0] ext);
        longint nx;
        longint ny;
        longint nz;
        t_u64   shl;
        t_u64   dmax;
        int     expo;
        int     est;
        int     base;
        int     level;
        if (ext > largest_chunk)
            return '0;
        if (shell_cells == 0)
            return LVL_W'(LEVEL_SAT);
        nx = longint'($signed(cx));
        ny = longint'($signed(cy));
        nz = longint'($signed(cz));
        shl = t_u64'(shell_cells);
        expo = int'($signed(scale_expo));
        dmax = mag64(nx - longint'($signed(cam_x)));
        if (mag64(ny - longint'($signed(cam_y))) > dmax)
            dmax = mag64(ny - longint'($signed(cam_y)));
        if (mag64(nz - longint'($signed(cam_z))) > dmax)
            dmax = mag64(nz - longint'($signed(cam_z)));
        // Estimate threshold is 2 * shell * 2^k chunks, a chunk being 16 voxels.
        est = 0;
        for (int k = 1; k + 5 + FRACTION_BITS < 64; k++)
            if ((dmax >> (k + 5 + FRACTION_BITS)) >= shl)
                est = k;
        // Grid of level L is 2^(L+2) * 2^expo chunks.
        base = 6 + expo + FRACTION_BITS;
        if (!shell_holds(est + base, nx, ny, nz, shl))
            level = est + 1;
        else if (est <= 0 || !shell_holds(est - 1 + base, nx, ny, nz, shl))
            level = est;
        else
            level = est - 1;
        if (level > LEVEL_SAT)
            level = LEVEL_SAT;
        return LVL_W'(level);
    endfunction

    function automatic t_stim_row node_row(input logic [COORD_BITS-1:0] cx,
                                           input logic [COORD_BITS-1:0] cy,
                                           input logic [COORD_BITS-1:0] cz,
                                           input logic [EXT_W-1:0] ext);
        t_stim_row r;
        r = '{ROW_NODE, REG_CAM_X, '0, cx, cy, cz, ext, 1'b0, '0};
        return r;
    endfunction

    function automatic t_stim_row fixed_row(input logic [COORD_BITS-1:0] cx,
                                            input logic [COORD_BITS-1:0] cy,
                                            input logic [COORD_BITS-1:0] cz,
                                            input logic [EXT_W-1:0] ext,
                                            input logic [LVL_W-1:0] level);
        t_stim_row r;
        r = node_row(cx, cy, cz, ext);
        r.known = 1'b1;
        r.level = level;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [IDX_W-1:0] idx,
                                          input logic [APB_DATA_W-1:0] val);
        t_stim_row r;
        r = '{ROW_CFG, idx, val, '0, '0, '0, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] coord_near(input logic [COORD_BITS-1:0] cam);
        logic [COORD_BITS-1:0] off;
        int                    span;
        span = $urandom_range(31, 0);
        if ($urandom_range(3) == 0)
            // Land close to a multiple of the shell width in grid units.
            off = ({24'd0, shell_cells} << $urandom_range(25, 8)) + $urandom_range(2) - 1;
        else
            off = $urandom >> (31 - span);
        if ($urandom_range(1) == 1)
            off = -off;
        return cam + off;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAM_X:   cam_x = val;
            REG_CAM_Y:   cam_y = val;
            REG_CAM_Z:   cam_z = val;
            REG_SHELL:   shell_cells = val[SHELL_W-1:0];
            REG_EXPO:    scale_expo = val[EXPO_W-1:0];
            REG_LARGEST: largest_chunk = val[EXT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic push_node(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                             input logic [COORD_BITS-1:0] cz, input logic [EXT_W-1:0] ext,
                             input bit known, input logic [LVL_W-1:0] level);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ext, cz, cy, cx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_levels.push_back(known ? level : predict_level(cx, cy, cz, ext));
    endtask

    // Each node yields a level, so an empty queue means the pipeline is empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int hold_left;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold != 0) begin
                hold_left = rx_hold;
                rx_hold = 0;
                m_tready <= 1'b0;
                repeat (hold_left) @(posedge i_clk);
            end
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: detail level beat with nothing pending: expected none, actual %0d",
                         $time, m_tdata[LVL_W-1:0]);
                errors++;
            end else begin
                want_level = pending_levels.pop_front();
                if (m_tdata[LVL_W-1:0] !== want_level) begin
                    $display("%0t: detail_level mismatch: expected %0d, actual %0d",
                             $time, want_level, m_tdata[LVL_W-1:0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] ry;
        logic [COORD_BITS-1:0] rz;
        logic [EXT_W-1:0]      re;
        logic [APB_DATA_W-1:0] cfg_word;

        errors        = 0;
        rx_hold       = 0;
        src_idle_pct  = 28;
        dst_idle_pct  = 65;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cam_x         = '0;
        cam_y         = '0;
        cam_z         = '0;
        shell_cells   = SHELL_RESET;
        scale_expo    = EXPO_RESET;
        largest_chunk = LARGEST_RESET;

        // Reset values first: camera at the origin, shell width 2, largest chunk 64.
        directed_rows.push_back(fixed_row(32'h0, 32'h0, 32'h0, 16'd0, 5'd0));
        directed_rows.push_back(fixed_row(32'h0000_1000, 32'h0, 32'h0, 16'hFFFF, 5'd0));
        directed_rows.push_back(node_row(32'h0010_0000, 32'hFFF0_0000, 32'h0, 16'd64));
        directed_rows.push_back(fixed_row(32'h0010_0000, 32'h0, 32'h0, 16'd65, 5'd0));
        directed_rows.push_back(node_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0));
        directed_rows.push_back(node_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd1));
        directed_rows.push_back(node_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0100, 16'd32));
        directed_rows.push_back(cfg_row(REG_LARGEST, 32'd0));
        directed_rows.push_back(node_row(32'h0000_4000, 32'h0000_4000, 32'h0, 16'd0));
        directed_rows.push_back(fixed_row(32'h0000_4000, 32'h0, 32'h0, 16'd1, 5'd0));
        directed_rows.push_back(cfg_row(REG_LARGEST, 32'h0000_FFFF));
        directed_rows.push_back(node_row(32'h0012_3456, 32'hFFED_CBA9, 32'h0, 16'hFFFF));
        // With no shell width nothing ever fits, so the level saturates.
        directed_rows.push_back(cfg_row(REG_SHELL, 32'd0));
        directed_rows.push_back(fixed_row(32'h0102_0304, 32'hFFFF_0000, 32'h55, 16'd5,
                                          LVL_W'(LEVEL_SAT)));
        directed_rows.push_back(cfg_row(REG_SHELL, 32'd255));
        directed_rows.push_back(node_row(32'h7000_0000, 32'h0, 32'h0, 16'd3));
        directed_rows.push_back(cfg_row(REG_SHELL, 32'd1));
        directed_rows.push_back(node_row(32'h0000_8000, 32'h0000_7FFF, 32'hFFFF_8000, 16'd2));
        directed_rows.push_back(node_row(32'h0400_0000, 32'h0, 32'h0, 16'd0));
        // Scale exponents beyond the nominal range, finest and coarsest grid.
        directed_rows.push_back(cfg_row(REG_EXPO, 32'h10));
        directed_rows.push_back(node_row(32'h40, 32'hFFFF_FFC0, 32'h1, 16'd0));
        directed_rows.push_back(node_row(32'h0100_0000, 32'h0, 32'h0, 16'd7));
        directed_rows.push_back(cfg_row(REG_EXPO, 32'h0F));
        directed_rows.push_back(node_row(32'h2000_0000, 32'h1000_0000, 32'h0, 16'd9));
        directed_rows.push_back(cfg_row(REG_CAM_X, 32'h8000_0000));
        directed_rows.push_back(cfg_row(REG_CAM_Y, 32'h7FFF_FFFF));
        directed_rows.push_back(cfg_row(REG_CAM_Z, 32'hFFFF_FF00));
        directed_rows.push_back(node_row(32'h0, 32'h0, 32'h0, 16'd0));
        directed_rows.push_back(node_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd64));
        directed_rows.push_back(cfg_row(REG_EXPO, 32'h18));
        directed_rows.push_back(cfg_row(REG_SHELL, 32'd3));
        directed_rows.push_back(node_row(32'h8000_1234, 32'h7FFF_0000, 32'h0, 16'd10));
        directed_rows.push_back(cfg_row(REG_EXPO, 32'h08));
        directed_rows.push_back(node_row(32'h9000_0000, 32'h6000_0000, 32'hF000_0000, 16'd11));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                push_node(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].cz,
                          directed_rows[i].ext, directed_rows[i].known, directed_rows[i].level);
            end
        end

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            wait_drained();
            if (seg < 3) begin
                src_idle_pct = 28;
                dst_idle_pct = 65;
            end else if (seg < 6) begin
                src_idle_pct = 65;
                dst_idle_pct = 28;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            write_reg(REG_CAM_X, (seg == 2) ? 32'h8000_0000 : $urandom);
            write_reg(REG_CAM_Y, (seg == 2) ? 32'h7FFF_FFFF : $urandom);
            write_reg(REG_CAM_Z, (seg == 2) ? 32'h0 : $urandom);
            case (seg)
                3:       cfg_word = 32'd1;
                4:       cfg_word = 32'd255;
                default: cfg_word = $urandom_range(12, 1);
            endcase
            write_reg(REG_SHELL, cfg_word);
            case (seg)
                0:       cfg_word = 32'h18;
                1:       cfg_word = 32'h08;
                5:       cfg_word = 32'h10;
                6:       cfg_word = 32'h0F;
                default: cfg_word = $urandom_range(16, 0) - 8;
            endcase
            write_reg(REG_EXPO, cfg_word);
            case (seg)
                0:       cfg_word = 32'd64;
                2:       cfg_word = 32'd0;
                7:       cfg_word = 32'h0000_FFFF;
                default: cfg_word = $urandom_range(65535, 0);
            endcase
            write_reg(REG_LARGEST, cfg_word);

            // A long receiver stall while nodes keep coming fills the pipeline.
            if (seg == 1 || seg == 6)
                rx_hold = HOLD_CYCLES;

            for (int n = 0; n < NODES_PER_SEGMENT; n++) begin
                if (seg == 4 && n == NODES_PER_SEGMENT / 2)
                    wait_drained();
                if ($urandom_range(9) == 0) begin
                    rx = $urandom;
                    ry = $urandom;
                    rz = $urandom;
                end else begin
                    rx = coord_near(cam_x);
                    ry = coord_near(cam_y);
                    rz = coord_near(cam_z);
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: re = EXT_W'($urandom_range(largest_chunk, 0));
                    7:                   re = largest_chunk + EXT_W'($urandom_range(1));
                    default:             re = EXT_W'($urandom);
                endcase
                push_node(rx, ry, rz, re, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        for (int n = 0; n < 20000 && pending_levels.size() != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_levels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/vlss_pkg.sv
rtl/core/vlss_cfg_regs.sv
rtl/core/vlss_estimate.sv
rtl/core/vlss_shell_fix.sv
rtl/core/voxel_lod_shell_select.sv
dv/tb_voxel_lod_shell_select.sv
